// ===== hw/rtl/ptdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptdc_pkg
// types and constants shared by the pwm tone divider calculation unit
// ----------------------------------------------------------------------------
package ptdc_pkg;

  localparam int unsigned SliceW  = 3;
  localparam int unsigned FreqW   = 16;
  localparam int unsigned DutyW   = 7;
  localparam int unsigned Div16W  = 12;
  localparam int unsigned WrapW   = 16;
  localparam int unsigned ProdW   = Div16W + FreqW;
  localparam int unsigned Quo1W   = 17;
  localparam int unsigned Quo2W   = 32;
  localparam int unsigned MulW    = WrapW + DutyW;
  localparam int unsigned RecipW  = 24;
  localparam int unsigned LevelW  = MulW + RecipW;

  localparam logic [FreqW-1:0]  MinFreq  = 16'd8;
  localparam logic [DutyW-1:0]  MaxDuty  = 7'd100;
  localparam logic [Div16W-1:0] DivOne   = 12'd16;
  localparam logic [Div16W-1:0] DivMax   = 12'hFFF;
  localparam logic [WrapW-1:0]  WrapMax  = 16'hFFFF;
  // floor(x / 100) = (x * ceil(2^30 / 100)) >> 30 for x below 2^23
  localparam logic [RecipW-1:0] PctRecip = 24'd10737419;
  localparam int unsigned       PctShift = 30;

  typedef struct packed {
    logic [SliceW-1:0] slice;
    logic              chan;
    logic [FreqW-1:0]  freq;
    logic [DutyW-1:0]  duty;
  } side1_t;

  typedef struct packed {
    logic [SliceW-1:0] slice;
    logic              chan;
    logic [DutyW-1:0]  duty;
    logic [Div16W-1:0] div16;
  } side2_t;

  typedef struct packed {
    logic [SliceW-1:0] slice;
    logic              chan;
    logic [7:0]        div_int;
    logic [3:0]        div_frac;
    logic [WrapW-1:0]  wrap;
    logic [WrapW-1:0]  level;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ptdc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptdc_div
// pipelined restoring divider, one quotient bit per stage, with sideband
// ----------------------------------------------------------------------------
module ptdc_div #(
  parameter int unsigned NW = 17,
  parameter int unsigned DW = 16,
  parameter int unsigned SW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [NW-1:0]      quo_o,
  output logic [SW-1:0]      side_o
);

  logic          vld_q  [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] num_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [NW-1:0] quo_q  [NW];
  logic [SW-1:0] side_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stg
    logic          vld_p;
    logic [DW-1:0] rem_p;
    logic [NW-1:0] num_p;
    logic [DW-1:0] den_p;
    logic [NW-1:0] quo_p;
    logic [SW-1:0] side_p;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_p  = valid_i;
      assign rem_p  = '0;
      assign num_p  = num_i;
      assign den_p  = den_i;
      assign quo_p  = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign num_p  = num_q[k-1];
      assign den_p  = den_q[k-1];
      assign quo_p  = quo_q[k-1];
      assign side_p = side_q[k-1];
    end

    assign trial = {rem_p, num_p[NW-1-k]};
    assign diff  = trial - {1'b0, den_p};
    assign ge    = (trial >= {1'b0, den_p});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        num_q[k]  <= num_p;
        den_q[k]  <= den_p;
        quo_q[k]  <= {quo_p[NW-2:0], ge};
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = quo_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/pwm_tone_divider_calc_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_tone_divider_calc_unit
// pwm clock divider, wrap and compare level from tone frequency and duty
// ----------------------------------------------------------------------------
// usage:
//   slave channel takes one request per transaction: tuser carries the slice
//   and channel tags, tdata the frequency in hertz and the duty in percent.
//   master channel returns one result per request, in request order, with
//   the tags in tuser and divider integer/fraction, wrap and compare level
//   in tdata.
//   an accepted request passes through 17 stages of the divider quotient,
//   1 clamp/multiply stage, 32 stages of the wrap quotient, 3 stages for
//   wrap, duty product and scaling by one hundredth, and the output
//   register on its way to the master channel.
//   throughput is one transaction per cycle while the skid register is empty;
//   every stage is a register. reset clears all valid bits, not data registers.
//   when the receiver stalls, the result holds in the output register and
//   one more lands in a skid register; s_axis_tready falls only while the
//   skid register is full, then the whole pipeline holds without loss.
// ----------------------------------------------------------------------------
module pwm_tone_divider_calc_unit #(
  parameter int unsigned CLOCK_HZ = 125000000
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // freq_hz[15:0], duty_percent[22:16]
  input  wire logic [3:0]  s_axis_tuser,  // slice_id[2:0], channel_id[3]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // div_integer, div_fraction, wrap_value,
                                          // compare_level, from bit 0 up
  output logic [3:0]       m_axis_tuser   // slice_out[2:0], channel_out[3]
);
  import ptdc_pkg::*;

  localparam logic [Quo1W-1:0] ClkBy4k = Quo1W'((CLOCK_HZ + 4095) / 4096);
  localparam logic [Quo2W-1:0] Clk16   = Quo2W'(64'(CLOCK_HZ) * 64'd16);

  logic pipe_en;

  // input clamp
  logic [FreqW-1:0] freq_c;
  logic [DutyW-1:0] duty_c;
  logic [Quo1W-1:0] num1;
  side1_t           side1_in;

  assign freq_c = (s_axis_tdata[15:0] < MinFreq) ? MinFreq : s_axis_tdata[15:0];
  assign duty_c = (s_axis_tdata[22:16] > MaxDuty) ? MaxDuty : s_axis_tdata[22:16];
  assign num1   = ClkBy4k + Quo1W'(freq_c) - Quo1W'(1);
  assign side1_in = '{slice: s_axis_tuser[2:0], chan: s_axis_tuser[3],
                      freq: freq_c, duty: duty_c};

  logic             d1_vld;
  logic [Quo1W-1:0] d1_quo;
  logic [$bits(side1_t)-1:0] d1_side_raw;
  side1_t           d1_side;

  ptdc_div #(.NW(Quo1W), .DW(FreqW), .SW($bits(side1_t))) u_div_span (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s_axis_tvalid),
    .num_i   (num1),
    .den_i   (freq_c),
    .side_i  (side1_in),
    .valid_o (d1_vld),
    .quo_o   (d1_quo),
    .side_o  (d1_side_raw)
  );
  assign d1_side = side1_t'(d1_side_raw);

  // stage a: clamp divider, divider times frequency
  logic [Div16W-1:0] div16_c;
  logic              a_vld_q;
  logic [ProdW-1:0]  a_prod_q;
  side2_t            a_side_q;

  always_comb begin
    if (d1_quo[Quo1W-1:4] == '0) begin
      div16_c = DivOne;
    end else if (d1_quo > Quo1W'(DivMax)) begin
      div16_c = DivMax;
    end else begin
      div16_c = d1_quo[Div16W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (pipe_en) begin
      a_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      a_prod_q <= ProdW'(div16_c) * ProdW'(d1_side.freq);
      a_side_q <= '{slice: d1_side.slice, chan: d1_side.chan,
                    duty: d1_side.duty, div16: div16_c};
    end
  end

  logic             d2_vld;
  logic [Quo2W-1:0] d2_quo;
  logic [$bits(side2_t)-1:0] d2_side_raw;
  side2_t           d2_side;

  ptdc_div #(.NW(Quo2W), .DW(ProdW), .SW($bits(side2_t))) u_div_period (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (a_vld_q),
    .num_i   (Clk16),
    .den_i   (a_prod_q),
    .side_i  (a_side_q),
    .valid_o (d2_vld),
    .quo_o   (d2_quo),
    .side_o  (d2_side_raw)
  );
  assign d2_side = side2_t'(d2_side_raw);

  // stage b: wrap with saturation
  logic [WrapW-1:0] wrap_c;
  logic             b_vld_q;
  logic [WrapW-1:0] b_wrap_q;
  side2_t           b_side_q;

  always_comb begin
    if (d2_quo == '0) begin
      wrap_c = '0;
    end else if (d2_quo > Quo2W'(65536)) begin
      wrap_c = WrapMax;
    end else begin
      wrap_c = WrapW'(d2_quo - Quo2W'(1));
    end
  end

  // stage c: wrap times duty, stage d: times reciprocal of one hundred
  logic             c_vld_q;
  logic [MulW-1:0]  c_mul_q;
  logic [WrapW-1:0] c_wrap_q;
  side2_t           c_side_q;
  logic             d_vld_q;
  logic [LevelW-1:0] d_prod_q;
  logic [WrapW-1:0] d_wrap_q;
  side2_t           d_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else if (pipe_en) begin
      b_vld_q <= d2_vld;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      b_wrap_q <= wrap_c;
      b_side_q <= d2_side;
      c_mul_q  <= MulW'(b_wrap_q) * MulW'(b_side_q.duty);
      c_wrap_q <= b_wrap_q;
      c_side_q <= b_side_q;
      d_prod_q <= LevelW'(c_mul_q) * LevelW'(PctRecip);
      d_wrap_q <= c_wrap_q;
      d_side_q <= c_side_q;
    end
  end

  result_t last_res;
  assign last_res = '{slice: d_side_q.slice, chan: d_side_q.chan,
                      div_int: d_side_q.div16[11:4], div_frac: d_side_q.div16[3:0],
                      wrap: d_wrap_q, level: d_prod_q[PctShift +: WrapW]};

  // output register and skid register
  logic    out_vld_q;
  result_t out_q;
  logic    skid_vld_q;
  result_t skid_q;
  logic    take;

  assign pipe_en = !skid_vld_q;
  assign take    = m_axis_tready || !out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (take) begin
      out_vld_q  <= skid_vld_q || d_vld_q;
      skid_vld_q <= 1'b0;
    end else if (d_vld_q && pipe_en) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= skid_vld_q ? skid_q : last_res;
    end else if (pipe_en) begin
      skid_q <= last_res;
    end
  end

  assign s_axis_tready = pipe_en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = {out_q.chan, out_q.slice};
  assign m_axis_tdata  = {4'd0, out_q.level, out_q.wrap, out_q.div_frac, out_q.div_int};

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register full while output register empty");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |=> out_vld_q)
    else $error("result dropped during stall");

  a_level_le_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.level <= out_q.wrap))
    else $error("compare level above wrap");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.div_int != 8'd0))
    else $error("divider integer part is zero");

endmodule
`default_nettype wire

// ===== dv/tb_pwm_tone_divider_calc_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pwm_tone_divider_calc_unit
// Sends tone requests into the divider unit and checks each result against
// a local calculation of divider, wrap and compare level. Directed corner
// cases come first, then random requests. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module tb_pwm_tone_divider_calc_unit;
  import ptdc_pkg::*;

  localparam int unsigned ClockHz   = 125000000;
  localparam int unsigned Latency   = 54;
  localparam longint      CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;

  result_t     tone_q[$];
  int          n_err = 0;
  longint      cyc = 0;
  bit          rx_stall_en = 1'b1;

  pwm_tone_divider_calc_unit #(.CLOCK_HZ(ClockHz)) u_top (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("tb_pwm_tone_divider_calc_unit: FAIL");
      $finish;
    end
  end

  function automatic result_t calc_tone(logic [2:0] slice, logic chan,
                                        logic [15:0] freq, logic [6:0] duty);
    result_t r;
    longint unsigned f, d, clk, span, div16, period, wrap;
    f = freq;
    d = duty;
    clk = ClockHz;
    if (f < 8) f = 8;
    if (d > 100) d = 100;
    span = f * 4096;
    div16 = clk / span + ((clk % span) != 0 ? 1 : 0);
    if ((div16 >> 4) == 0) div16 = 16;
    if (div16 > 4095) div16 = 4095;
    period = (clk * 16) / div16 / f;
    wrap = (period > 0) ? period - 1 : 0;
    if (wrap > 65535) wrap = 65535;
    r.slice    = slice;
    r.chan     = chan;
    r.div_int  = div16[11:4];
    r.div_frac = div16[3:0];
    r.wrap     = wrap[15:0];
    r.level    = 16'((wrap * d) / 100);
    return r;
  endfunction

  // valid stays high after a transaction; the next call drops it only for a gap
  task automatic send_tone(logic [2:0] slice, logic chan, logic [15:0] freq,
                           logic [6:0] duty, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 14) : 0;
    if (gaps && $urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, duty, freq};
    s_axis_tuser  <= {chan, slice};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tone_q.push_back(calc_tone(slice, chan, freq, duty));
    @(negedge clk_i);
  endtask

  // result side: random stall per transaction, checked at the rising edge
  initial begin
    int stall;
    result_t exp_r, got;
    forever begin
      @(negedge clk_i);
      stall = rx_stall_en ? $urandom_range(0, 14) : 0;
      if (rx_stall_en && $urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got.slice    = m_axis_tuser[2:0];
      got.chan     = m_axis_tuser[3];
      got.div_int  = m_axis_tdata[7:0];
      got.div_frac = m_axis_tdata[11:8];
      got.wrap     = m_axis_tdata[27:12];
      got.level    = m_axis_tdata[43:28];
      if (tone_q.size() == 0) begin
        $error("result with no request pending");
        n_err++;
      end else begin
        exp_r = tone_q.pop_front();
        if (got.slice !== exp_r.slice) begin
          $error("slice_out exp %0d got %0d", exp_r.slice, got.slice); n_err++;
        end
        if (got.chan !== exp_r.chan) begin
          $error("channel_out exp %0d got %0d", exp_r.chan, got.chan); n_err++;
        end
        if (got.div_int !== exp_r.div_int) begin
          $error("div_integer exp %0d got %0d", exp_r.div_int, got.div_int); n_err++;
        end
        if (got.div_frac !== exp_r.div_frac) begin
          $error("div_fraction exp %0d got %0d", exp_r.div_frac, got.div_frac);
          n_err++;
        end
        if (got.wrap !== exp_r.wrap) begin
          $error("wrap_value exp %0d got %0d", exp_r.wrap, got.wrap); n_err++;
        end
        if (got.level !== exp_r.level) begin
          $error("compare_level exp %0d got %0d", exp_r.level, got.level); n_err++;
        end
      end
    end
  end

  task automatic test_corners();
    send_tone(3'd0, 1'b0, 16'd0, 7'd0, 1'b0);
    send_tone(3'd7, 1'b1, 16'd7, 7'd100, 1'b0);
    send_tone(3'd5, 1'b0, 16'd8, 7'd50, 1'b0);
    send_tone(3'd2, 1'b1, 16'd65535, 7'd127, 1'b0);
    send_tone(3'd1, 1'b0, 16'd1, 7'd101, 1'b0);
    send_tone(3'd6, 1'b1, 16'd30518, 7'd99, 1'b0);
    send_tone(3'd3, 1'b0, 16'd30517, 7'd1, 1'b0);
    send_tone(3'd4, 1'b1, 16'd440, 7'd64, 1'b0);
    send_tone(3'd7, 1'b0, 16'd32768, 7'd33, 1'b0);
    send_tone(3'd0, 1'b1, 16'd9, 7'd100, 1'b0);
  endtask

  task automatic test_back_to_back();
    rx_stall_en = 1'b0;
    for (int i = 0; i < 60; i++)
      send_tone(3'($urandom), 1'($urandom), 16'($urandom), 7'($urandom), 1'b0);
    rx_stall_en = 1'b1;
  endtask

  task automatic test_random();
    logic [15:0] f;
    for (int i = 0; i < 480; i++) begin
      case ($urandom_range(0, 3))
        0: f = 16'($urandom);
        1: f = 16'($urandom_range(0, 64));
        2: f = 16'($urandom_range(20000, 40000));
        default: f = 16'($urandom_range(100, 5000));
      endcase
      send_tone(3'($urandom), 1'($urandom), f,
                ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100)),
                1'b1);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    test_corners();
    test_back_to_back();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (tone_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    if (n_err == 0) $display("tb_pwm_tone_divider_calc_unit: PASS");
    else $display("tb_pwm_tone_divider_calc_unit: FAIL");
    $finish;
  end

endmodule
